// File: hw/rtl/nfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA field extractor package
// Shared constants, character codes, tag table, and the structs passed
// between the sentence tracker, the field accumulator and the result logic.
// ----------------------------------------------------------------------------
package nfe_pkg;

	// Field format limits.
	localparam int MAX_FRACTION_DIGITS = 5;
	localparam int MAX_INTEGER_DIGITS  = 9;
	localparam int FDC_W = $clog2(MAX_FRACTION_DIGITS + 1);
	localparam int IDC_W = $clog2(MAX_INTEGER_DIGITS + 1);
	// Bits for the largest digit string: digits times log2(10), plus one.
	localparam int MAG_W = ((MAX_INTEGER_DIGITS + MAX_FRACTION_DIGITS) * 3322) / 1000 + 1;
	localparam int MANT_W = 48;
	localparam logic [63:0] MANT_MAX = 64'h0000_7FFF_FFFF_FFFF;

	// Power of ten, evaluated at elaboration only.
	function automatic logic [63:0] pow10(input int n);
		logic [63:0] r;
		r = 64'd1;
		for (int i = 0; i < n; i++) begin
			r = r * 64'd10;
		end
		return r;
	endfunction

	// Integer part held at all nines once it saturates.
	localparam logic [MAG_W-1:0] SAT_VALUE = MAG_W'(pow10(MAX_INTEGER_DIGITS) - 64'd1);

	// Character codes.
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UP_S   = 8'h53;
	localparam logic [7:0] CH_UP_W   = 8'h57;
	localparam logic [7:0] CH_LO_S   = 8'h73;
	localparam logic [7:0] CH_LO_W   = 8'h77;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;

	// Last tag position after the dollar sign; the tag is five characters long.
	localparam logic [2:0] TAG_LAST = 3'd4;
	localparam int NUM_KINDS = 3;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_TAG  = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_GGA = 2'd0,
		KIND_DHV = 2'd1,
		KIND_VTG = 2'd2
	} kind_t;

	// Expected tag character for a sentence kind at a tag position.
	function automatic logic [7:0] tag_char(input logic [1:0] kind, input logic [2:0] pos);
		logic [7:0] c;
		c = 8'h00;
		case (pos)
			3'd0: c = 8'h47;                                      // G
			3'd1: c = 8'h4E;                                      // N
			3'd2: c = (kind == KIND_GGA) ? 8'h47 : (kind == KIND_DHV) ? 8'h44 : 8'h56;
			3'd3: c = (kind == KIND_GGA) ? 8'h47 : (kind == KIND_DHV) ? 8'h48 : 8'h54;
			3'd4: c = (kind == KIND_GGA) ? 8'h41 : (kind == KIND_DHV) ? 8'h56 : 8'h47;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Per-byte commands from the sentence tracker.
	typedef struct packed {
		logic       take;
		logic       clr;
		logic       finish;
		logic       force_bad;
		kind_t      kind;
		logic [3:0] field_num;
	} ctrl_t;

	// Current field accumulation state.
	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic [FDC_W-1:0] fdc;
		logic             dot;
		logic             minus;
		logic             bad;
		logic             seen;
		logic             sat;
		logic [7:0]       first_char;
	} field_t;

	// One result transaction.
	typedef struct packed {
		logic [1:0]               kind;
		logic [3:0]               field_num;
		logic signed [MANT_W-1:0] mantissa;
		logic [2:0]               decimals;
		logic                     hemi;
		logic                     ovf;
	} result_t;

endpackage
`default_nettype wire

// File: hw/rtl/nfe_sentence.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA sentence tracker
// Matches the talker tag after a dollar sign, counts commas in the body and
// tells the field accumulator when to take, clear and report a field.
// ----------------------------------------------------------------------------
module nfe_sentence (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [7:0]    byte_in,
	output nfe_pkg::ctrl_t     ctrl
);

	nfe_pkg::phase_t phase_q, phase_d;
	logic [2:0] pos_q, pos_d;
	logic [2:0] cand_q, cand_d;
	logic [3:0] comma_q, comma_d;
	logic [2:0] mismatch;
	nfe_pkg::kind_t kind;

	// Tag mismatch per candidate at the current position.
	always_comb begin
		for (int c = 0; c < nfe_pkg::NUM_KINDS; c++) begin
			mismatch[c] = (nfe_pkg::tag_char(2'(c), pos_q) != byte_in);
		end
	end

	// Sentence kind from the one surviving candidate.
	always_comb begin
		if (cand_q[0]) begin
			kind = nfe_pkg::KIND_GGA;
		end else if (cand_q[1]) begin
			kind = nfe_pkg::KIND_DHV;
		end else begin
			kind = nfe_pkg::KIND_VTG;
		end
	end

	// Next state and per-byte commands.
	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		cand_d  = cand_q;
		comma_d = comma_q;
		ctrl    = '0;
		ctrl.kind      = kind;
		ctrl.field_num = comma_q;
		if (step) begin
			if (byte_in == nfe_pkg::CH_DOLLAR) begin
				phase_d  = nfe_pkg::PH_TAG;
				pos_d    = 3'd0;
				cand_d   = 3'b111;
				comma_d  = 4'd0;
				ctrl.clr = 1'b1;
			end else begin
				unique case (phase_q)
					nfe_pkg::PH_TAG: begin
						cand_d = cand_q & ~mismatch;
						if ((cand_q & ~mismatch) == 3'b000) begin
							phase_d = nfe_pkg::PH_IDLE;
						end else begin
							pos_d = pos_q + 3'd1;
							if (pos_q == nfe_pkg::TAG_LAST) begin
								phase_d  = nfe_pkg::PH_BODY;
								comma_d  = 4'd0;
								ctrl.clr = 1'b1;
							end
						end
					end
					nfe_pkg::PH_BODY: begin
						if (byte_in == nfe_pkg::CH_COMMA) begin
							ctrl.finish = 1'b1;
							ctrl.clr    = 1'b1;
							if (comma_q != 4'd15) begin
								comma_d = comma_q + 4'd1;
							end
						end else if (byte_in == nfe_pkg::CH_STAR ||
								byte_in < nfe_pkg::CH_SPACE ||
								byte_in > nfe_pkg::CH_LO_Z) begin
							ctrl.finish    = 1'b1;
							ctrl.force_bad = (byte_in != nfe_pkg::CH_STAR);
							ctrl.clr       = 1'b1;
							phase_d        = nfe_pkg::PH_IDLE;
						end else if (comma_q != 4'd0) begin
							ctrl.take = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= nfe_pkg::PH_IDLE;
			pos_q   <= 3'd0;
			cand_q  <= 3'b111;
			comma_q <= 4'd0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			cand_q  <= cand_d;
			comma_q <= comma_d;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/nfe_field_acc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA field accumulator
// Builds the decimal mantissa of the open field one character at a time,
// integer and fraction digits in a single running value, with the syntax
// flags and the first character of the field.
// ----------------------------------------------------------------------------
module nfe_field_acc (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire nfe_pkg::ctrl_t ctrl,
	input  wire logic [7:0]    byte_in,
	output nfe_pkg::field_t    field
);

	nfe_pkg::field_t fld_q, fld_d;
	logic [nfe_pkg::IDC_W-1:0] idc_q, idc_d;
	logic [nfe_pkg::MAG_W-1:0] mag_x10;
	logic is_digit;

	assign is_digit = (byte_in >= nfe_pkg::CH_ZERO) && (byte_in <= nfe_pkg::CH_NINE);
	// Shift-and-add by ten with the new digit appended.
	assign mag_x10  = (fld_q.mag << 3) + (fld_q.mag << 1) +
		nfe_pkg::MAG_W'(byte_in[3:0]);

	// Character classification and accumulation.
	always_comb begin
		fld_d = fld_q;
		idc_d = idc_q;
		if (ctrl.clr) begin
			fld_d = '0;
			idc_d = '0;
		end else if (ctrl.take) begin
			fld_d.seen = 1'b1;
			if (!fld_q.seen) begin
				fld_d.first_char = byte_in;
			end
			if (!fld_q.bad) begin
				if (byte_in == nfe_pkg::CH_MINUS && !fld_q.seen) begin
					fld_d.minus = 1'b1;
				end else if (byte_in == nfe_pkg::CH_DOT) begin
					if (fld_q.dot) begin
						fld_d.bad = 1'b1;
					end else begin
						fld_d.dot = 1'b1;
					end
				end else if (is_digit) begin
					if (fld_q.dot) begin
						if (fld_q.fdc < nfe_pkg::FDC_W'(nfe_pkg::MAX_FRACTION_DIGITS)) begin
							fld_d.mag = mag_x10;
							fld_d.fdc = fld_q.fdc + 1'b1;
						end
					end else if (!fld_q.sat) begin
						if (idc_q < nfe_pkg::IDC_W'(nfe_pkg::MAX_INTEGER_DIGITS)) begin
							fld_d.mag = mag_x10;
							idc_d     = idc_q + 1'b1;
						end else begin
							fld_d.sat = 1'b1;
							fld_d.mag = nfe_pkg::SAT_VALUE;
						end
					end
				end else begin
					fld_d.bad = 1'b1;
				end
			end
		end
	end

	// Field registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fld_q <= '0;
			idc_q <= '0;
		end else begin
			fld_q <= fld_d;
			idc_q <= idc_d;
		end
	end

	assign field = fld_q;

endmodule
`default_nettype wire

// File: hw/rtl/nfe_result.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA field result logic
// Decides whether a finished field is reported and forms its signed
// mantissa, decimals, hemisphere and overflow indication.
// ----------------------------------------------------------------------------
module nfe_result (
	input  wire nfe_pkg::ctrl_t  ctrl,
	input  wire nfe_pkg::field_t field,
	output logic                 has_result,
	output nfe_pkg::result_t     result
);

	logic        gga;
	logic        hemi_field;
	logic        numeric_sel;
	logic        always_report;
	logic        good;
	logic [63:0] mag_wide;
	logic [63:0] mag;
	logic        ovf;
	logic [3:0]  n;

	assign n   = ctrl.field_num;
	assign gga = (ctrl.kind == nfe_pkg::KIND_GGA);
	assign hemi_field    = gga && (n == 4'd3 || n == 4'd5);
	assign always_report = gga && (n == 4'd6 || n == 4'd7);
	assign good     = !ctrl.force_bad && !field.bad;
	assign mag_wide = 64'(field.mag);

	// Fields carried for each sentence kind.
	always_comb begin
		unique case (ctrl.kind)
			nfe_pkg::KIND_GGA: numeric_sel = (n == 4'd1 || n == 4'd2 || n == 4'd4 ||
				n == 4'd6 || n == 4'd7 || n == 4'd8 || n == 4'd9);
			nfe_pkg::KIND_DHV: numeric_sel = (n == 4'd3 || n == 4'd4 || n == 4'd5);
			nfe_pkg::KIND_VTG: numeric_sel = (n == 4'd1 || n == 4'd7);
			default:           numeric_sel = 1'b0;
		endcase
	end

	// Magnitude with clamping to the signed output range.
	always_comb begin
		mag = 64'd0;
		ovf = 1'b0;
		if (!hemi_field && good) begin
			ovf = field.sat;
			if (mag_wide > nfe_pkg::MANT_MAX) begin
				mag = nfe_pkg::MANT_MAX;
				ovf = 1'b1;
			end else begin
				mag = mag_wide;
			end
		end
	end

	// Report decision and payload.
	always_comb begin
		has_result = 1'b0;
		if (ctrl.finish && n != 4'd0) begin
			if (hemi_field) begin
				has_result = 1'b1;
			end else if (numeric_sel) begin
				has_result = (mag != 64'd0) || always_report;
			end
		end
		result.kind      = ctrl.kind;
		result.field_num = n;
		result.mantissa  = field.minus ? -nfe_pkg::MANT_W'(mag) : nfe_pkg::MANT_W'(mag);
		result.decimals  = (!hemi_field && good) ? 3'(field.fdc) : 3'd0;
		result.ovf       = ovf;
		if (n == 4'd3) begin
			result.hemi = hemi_field && (field.first_char == nfe_pkg::CH_UP_S ||
				field.first_char == nfe_pkg::CH_LO_S);
		end else begin
			result.hemi = hemi_field && (field.first_char == nfe_pkg::CH_UP_W ||
				field.first_char == nfe_pkg::CH_LO_W);
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/nmea_field_extractor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA field extractor
// Streaming parser that pulls numeric fields out of GNGGA, GNDHV and GNVTG
// sentences and reports each as a signed decimal mantissa.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, rx_byte) takes one received
// character per transaction. The output channel (out_valid, out_stall and
// the result fields) gives one transaction per reported field, at the
// comma, star or control character that closes it.
// Each accepted byte is held in an input register and processed when the
// result register is free or drains; a reported field is then held in the
// result register. A byte can be taken every cycle while in_stall is low.
// The output register holds a result while out_stall is high; the input
// register then holds its byte and in_stall rises only when that byte
// must wait behind the stalled result.
// Reset clears the parser to waiting for a dollar sign and empties both
// registers. Degree conversion and scaling of the mantissa are left to
// software.
// ----------------------------------------------------------------------------
module nmea_field_extractor (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [7:0]                 rx_byte,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [1:0]                      sentence_kind,
	output logic [3:0]                      field_number,
	output logic signed [nfe_pkg::MANT_W-1:0] mantissa,
	output logic [2:0]                      decimals,
	output logic                            hemisphere_negative,
	output logic                            digit_overflow
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;
	logic             step;
	logic             has_result;
	nfe_pkg::ctrl_t   ctrl;
	nfe_pkg::field_t  field;
	nfe_pkg::result_t result;
	logic             out_valid_q;
	nfe_pkg::result_t result_q;

	// The processing stage moves when the result register is free or drains.
	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	nfe_sentence u_sentence (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.ctrl    (ctrl)
	);

	nfe_field_acc u_field_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.byte_in (byte_s1),
		.field   (field)
	);

	nfe_result u_result (
		.ctrl       (ctrl),
		.field      (field),
		.has_result (has_result),
		.result     (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (step && has_result) begin
			result_q <= result;
		end
	end

	assign out_valid           = out_valid_q;
	assign sentence_kind       = result_q.kind;
	assign field_number        = result_q.field_num;
	assign mantissa            = result_q.mantissa;
	assign decimals            = result_q.decimals;
	assign hemisphere_negative = result_q.hemi;
	assign digit_overflow      = result_q.ovf;

`ifndef SYNTH
	// The input side only waits when a byte is held behind a stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("in_stall without a held byte behind a stalled result");

	// Kept fraction digits never exceed the configured limit.
	a_decimals: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (decimals <= 3'(nfe_pkg::MAX_FRACTION_DIGITS)))
		else $error("decimals beyond the fraction digit limit");

	// A hemisphere flag only comes with GGA latitude or longitude letters.
	a_hemi: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hemisphere_negative) |->
		(sentence_kind == nfe_pkg::KIND_GGA && (field_number == 4'd3 ||
		field_number == 4'd5) && mantissa == '0))
		else $error("hemisphere flag on a field that is not a hemisphere letter");
`endif

endmodule
`default_nettype wire

// File: test/nmea_field_extractor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA field extractor testbench
// Feeds the extractor a stream of characters: first a short list of
// hand-written sentences, then random sentences with noise, broken tags and
// malformed fields. A behavioral parser predicts the reported fields; typed
// rows carry their own. Each accepted output transaction is checked against
// the oldest prediction. Both channels idle at random but in the last phase.
// ----------------------------------------------------------------------------
module nmea_field_extractor_tb;
	import nfe_pkg::*;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int PHASE_BYTES   = 425;
	localparam logic [39:0] TAG_TEXT [3] = '{"GNGGA", "GNDHV", "GNVTG"};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic out_stall = 1'b0;
	logic in_stall;
	logic out_valid;
	logic [1:0] sentence_kind;
	logic [3:0] field_number;
	logic signed [MANT_W-1:0] mantissa;
	logic [2:0] decimals;
	logic hemisphere_negative;
	logic digit_overflow;

	// Idle rates in percent for the sender and the receiver.
	int send_gap_pct = 0;
	int recv_stall_pct = 0;

	int err_count = 0;
	int cycle_count = 0;
	bit typed_row = 1'b0;
	result_t field_q [$];
	logic [7:0] line_q [$];
	result_t want;
	result_t got;

	// Directed sentence list.
	string row_text [$];
	bit row_typed [$];
	result_t row_exp [$];

	// Parser state of the predictor.
	phase_t trk_phase;
	logic [2:0] trk_tag_pos;
	logic [2:0] trk_live;
	logic [3:0] trk_commas;
	logic [63:0] acc_int;
	logic [63:0] acc_frac;
	int int_digits;
	int frac_digits;
	logic fl_dot, fl_minus, fl_bad, fl_seen, fl_sat;
	logic [7:0] fl_first;

	nmea_field_extractor uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sentence_kind(sentence_kind),
		.field_number(field_number),
		.mantissa(mantissa),
		.decimals(decimals),
		.hemisphere_negative(hemisphere_negative),
		.digit_overflow(digit_overflow)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic logic [63:0] tens(input int n);
		logic [63:0] r;
		r = 64'd1;
		repeat (n) r = r * 64'd10;
		return r;
	endfunction

	// Numeric fields that the extractor reports for each sentence kind.
	function automatic bit numeric_field(input kind_t k, input logic [3:0] n);
		case (k)
			KIND_GGA: return n inside {4'd1, 4'd2, 4'd4, 4'd6, 4'd7, 4'd8, 4'd9};
			KIND_DHV: return n inside {4'd3, 4'd4, 4'd5};
			default:  return n inside {4'd1, 4'd7};
		endcase
	endfunction

	function automatic result_t field_of(input kind_t k, input logic [3:0] n,
			input logic signed [MANT_W-1:0] m, input logic [2:0] d, input logic h,
			input logic o);
		result_t r;
		r.kind = k;
		r.field_num = n;
		r.mantissa = m;
		r.decimals = d;
		r.hemi = h;
		r.ovf = o;
		return r;
	endfunction

	task clear_field_state;
		acc_int = 64'd0;
		acc_frac = 64'd0;
		int_digits = 0;
		frac_digits = 0;
		fl_dot = 1'b0;
		fl_minus = 1'b0;
		fl_bad = 1'b0;
		fl_seen = 1'b0;
		fl_sat = 1'b0;
		fl_first = 8'h00;
	endtask

	task reset_tracker;
		trk_phase = PH_IDLE;
		trk_tag_pos = 3'd0;
		trk_live = 3'b111;
		trk_commas = 4'd0;
		clear_field_state();
	endtask

	// Report the field that a comma, star or control character closes.
	task automatic close_field(input kind_t k, input bit force_bad, output bit hit,
			output result_t r);
		logic [63:0] mag;
		logic [2:0] dec;
		logic ovf;
		logic hemi;
		hit = 1'b0;
		r = '0;
		mag = 64'd0;
		dec = 3'd0;
		ovf = 1'b0;
		hemi = 1'b0;
		if (trk_commas == 4'd0)
			return;
		if (k == KIND_GGA && (trk_commas == 4'd3 || trk_commas == 4'd5)) begin
			if (trk_commas == 4'd3)
				hemi = (fl_first == CH_UP_S || fl_first == CH_LO_S);
			else
				hemi = (fl_first == CH_UP_W || fl_first == CH_LO_W);
		end else if (numeric_field(k, trk_commas)) begin
			if (!force_bad && !fl_bad) begin
				dec = 3'(frac_digits);
				mag = acc_int * tens(frac_digits) + acc_frac;
				ovf = fl_sat;
				if (mag > MANT_MAX) begin
					mag = MANT_MAX;
					ovf = 1'b1;
				end
			end
			// Zero values are dropped, except quality and satellite count.
			if (mag == 64'd0 && !(k == KIND_GGA && (trk_commas == 4'd6 || trk_commas == 4'd7)))
				return;
		end else begin
			return;
		end
		hit = 1'b1;
		r = field_of(k, trk_commas, fl_minus ? (48'd0 - mag[47:0]) : mag[47:0], dec, hemi, ovf);
	endtask

	// Accumulate one character of the open field.
	task automatic take_field_char(input logic [7:0] b);
		bit first;
		first = !fl_seen;
		if (first)
			fl_first = b;
		fl_seen = 1'b1;
		if (fl_bad)
			return;
		if (b == CH_MINUS && first) begin
			fl_minus = 1'b1;
		end else if (b == CH_DOT) begin
			if (fl_dot)
				fl_bad = 1'b1;
			else
				fl_dot = 1'b1;
		end else if (b >= CH_ZERO && b <= CH_NINE) begin
			if (fl_dot) begin
				if (frac_digits < MAX_FRACTION_DIGITS) begin
					acc_frac = acc_frac * 64'd10 + 64'(b - CH_ZERO);
					frac_digits++;
				end
			end else if (!fl_sat) begin
				if (int_digits < MAX_INTEGER_DIGITS) begin
					acc_int = acc_int * 64'd10 + 64'(b - CH_ZERO);
					int_digits++;
				end else begin
					fl_sat = 1'b1;
					acc_int = tens(MAX_INTEGER_DIGITS) - 64'd1;
				end
			end
		end else begin
			fl_bad = 1'b1;
		end
	endtask

	// Advance the parser by one character and return the field it closes, if any.
	task automatic predict_char(input logic [7:0] b, output bit hit, output result_t r);
		kind_t k;
		int tp;
		hit = 1'b0;
		r = '0;
		if (b == CH_DOLLAR) begin
			trk_phase = PH_TAG;
			trk_tag_pos = 3'd0;
			trk_live = 3'b111;
			trk_commas = 4'd0;
			clear_field_state();
			return;
		end
		if (trk_phase == PH_TAG) begin
			tp = int'(trk_tag_pos);
			for (int c = 0; c < 3; c++) begin
				if (tp < 5 && TAG_TEXT[c][39 - 8 * tp -: 8] != b)
					trk_live[c] = 1'b0;
			end
			if (trk_live == 3'b000 || tp >= 5) begin
				trk_phase = PH_IDLE;
			end else begin
				trk_tag_pos++;
				if (trk_tag_pos == 3'd5) begin
					trk_phase = PH_BODY;
					trk_commas = 4'd0;
					clear_field_state();
				end
			end
			return;
		end
		if (trk_phase != PH_BODY)
			return;
		k = trk_live[0] ? KIND_GGA : (trk_live[1] ? KIND_DHV : KIND_VTG);
		if (b == CH_COMMA) begin
			close_field(k, 1'b0, hit, r);
			if (trk_commas < 4'd15)
				trk_commas++;
			clear_field_state();
		end else if (b == CH_STAR || b < CH_SPACE || b > CH_LO_Z) begin
			close_field(k, b != CH_STAR, hit, r);
			trk_phase = PH_IDLE;
			clear_field_state();
		end else if (trk_commas >= 4'd1) begin
			take_field_char(b);
		end
	endtask

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b);
		bit hit;
		result_t fld;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_char(b, hit, fld);
		if (hit && !typed_row)
			field_q.push_back(fld);
	endtask

	task add_row(input string s, input bit typed, input result_t e);
		row_text.push_back(s);
		row_typed.push_back(typed);
		row_exp.push_back(e);
	endtask

	task push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_q.push_back(s[i]);
	endtask

	// A decimal number, sometimes signed, sometimes all zeros or too long.
	task automatic add_number;
		int nint;
		int nfrac;
		bit zeros;
		zeros = ($urandom_range(5) == 0);
		if ($urandom_range(3) == 0)
			line_q.push_back(CH_MINUS);
		nint = ($urandom_range(9) == 0) ? $urandom_range(10, 13) : $urandom_range(0, 6);
		repeat (nint)
			line_q.push_back(zeros ? CH_ZERO : CH_ZERO + 8'($urandom_range(9)));
		if ($urandom_range(1)) begin
			line_q.push_back(CH_DOT);
			nfrac = ($urandom_range(9) == 0) ? $urandom_range(6, 8) : $urandom_range(0, 5);
			repeat (nfrac)
				line_q.push_back(zeros ? CH_ZERO : CH_ZERO + 8'($urandom_range(9)));
		end
	endtask

	task automatic add_field;
		string letters;
		int pick;
		int pos;
		letters = "NSEWnsewMX";
		pick = $urandom_range(99);
		if (pick < 15) begin
			// Empty field.
		end else if (pick < 65) begin
			add_number();
		end else if (pick < 82) begin
			line_q.push_back(letters[$urandom_range(letters.len() - 1)]);
		end else begin
			// Malformed number: a stray printable character somewhere inside.
			pos = line_q.size();
			add_number();
			line_q.insert($urandom_range(pos, line_q.size()), 8'($urandom_range(8'h20, 8'h7A)));
		end
	endtask

	// One random sentence, mostly well formed, into the line queue.
	task automatic add_sentence;
		string hexd;
		int k;
		int nfields;
		int pick;
		logic [39:0] tag;
		hexd = "0123456789ABCDEF";
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 6))
				line_q.push_back(8'($urandom_range(255)));
		end
		k = $urandom_range(2);
		tag = TAG_TEXT[k];
		if ($urandom_range(99) < 12)
			tag[8 * $urandom_range(4) +: 8] = 8'($urandom_range(8'h41, 8'h5A));
		line_q.push_back(CH_DOLLAR);
		for (int p = 4; p >= 0; p--)
			line_q.push_back(tag[8 * p +: 8]);
		nfields = ($urandom_range(14) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 11);
		repeat (nfields) begin
			line_q.push_back(CH_COMMA);
			add_field();
		end
		if ($urandom_range(19) == 0)
			line_q.push_back(8'($urandom_range(255)));
		pick = $urandom_range(99);
		if (pick < 70) begin
			line_q.push_back(CH_STAR);
			line_q.push_back(hexd[$urandom_range(15)]);
			line_q.push_back(hexd[$urandom_range(15)]);
			push_text("\r\n");
		end else if (pick < 80) begin
			line_q.push_back(8'($urandom_range(8'h1F)));
		end else if (pick < 90) begin
			line_q.push_back(8'($urandom_range(8'h7B, 8'hFF)));
		end
	endtask

	// ------------------------------------------------------------------
	// Output side
	// ------------------------------------------------------------------
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	// Compare each accepted result transaction with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got = field_of(kind_t'(sentence_kind), field_number, mantissa, decimals,
				hemisphere_negative, digit_overflow);
			if (field_q.size() == 0) begin
				err_count++;
				$display("%0t: unexpected field: expected none, actual kind %0d num %0d mant %0d dec %0d hemi %0d ovf %0d",
					$time, got.kind, got.field_num, got.mantissa, got.decimals, got.hemi,
					got.ovf);
			end else begin
				want = field_q.pop_front();
				if (got.kind !== want.kind || got.field_num !== want.field_num
						|| got.mantissa !== want.mantissa || got.decimals !== want.decimals
						|| got.hemi !== want.hemi || got.ovf !== want.ovf) begin
					err_count++;
					$display("%0t: mismatch: expected kind %0d num %0d mant %0d dec %0d hemi %0d ovf %0d, actual kind %0d num %0d mant %0d dec %0d hemi %0d ovf %0d",
						$time, want.kind, want.field_num, want.mantissa, want.decimals,
						want.hemi, want.ovf, got.kind, got.field_num, got.mantissa,
						got.decimals, got.hemi, got.ovf);
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout with %0d fields still expected", field_q.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		int sent;
		reset_tracker();

		// Typical sentences of each kind.
		add_row("$GNGGA,092750.000,5321.6802,N,00630.3372,W,1,8,1.03,61.7,M,55.2,M,,*76\r\n",
			1'b0, '0);
		add_row("$GNDHV,021150.000,0.03,0.006,-0.042,-0.026,0.06*65\r\n", 1'b0, '0);
		add_row("$GNVTG,54.7,T,34.4,M,005.5,N,010.2,K*48\r\n", 1'b0, '0);
		// Hemisphere letters, closed by a star and by a control character.
		add_row("$GNGGA,,,S*", 1'b1, field_of(KIND_GGA, 4'd3, 48'sd0, 3'd0, 1'b1, 1'b0));
		add_row("$GNGGA,,,S\n", 1'b1, field_of(KIND_GGA, 4'd3, 48'sd0, 3'd0, 1'b1, 1'b0));
		add_row("$GNGGA,,,s,,w,1*", 1'b0, '0);
		// Largest and smallest mantissas.
		add_row("$GNGGA,999999999.99999*", 1'b1,
			field_of(KIND_GGA, 4'd1, 48'sd99999999999999, 3'd5, 1'b0, 1'b0));
		add_row("$GNGGA,-999999999.99999*", 1'b1,
			field_of(KIND_GGA, 4'd1, -48'sd99999999999999, 3'd5, 1'b0, 1'b0));
		add_row("$GNVTG,-0.12345*", 1'b1, field_of(KIND_VTG, 4'd1, -48'sd12345, 3'd5, 1'b0, 1'b0));
		add_row("$GNVTG,,,,,,,-0.50*", 1'b1, field_of(KIND_VTG, 4'd7, -48'sd50, 3'd2, 1'b0, 1'b0));
		// Integer saturation and fraction truncation.
		add_row("$GNDHV,,,9999999999*", 1'b1,
			field_of(KIND_DHV, 4'd3, 48'sd999999999, 3'd0, 1'b0, 1'b1));
		add_row("$GNVTG,1.123456789*", 1'b1, field_of(KIND_VTG, 4'd1, 48'sd112345, 3'd5, 1'b0, 1'b0));
		// Bare dot at the front and at the end of a field.
		add_row("$GNVTG,.5*", 1'b1, field_of(KIND_VTG, 4'd1, 48'sd5, 3'd1, 1'b0, 1'b0));
		add_row("$GNVTG,5.*", 1'b1, field_of(KIND_VTG, 4'd1, 48'sd5, 3'd0, 1'b0, 1'b0));
		// Zero suppression, and the quality and satellite fields that escape it.
		add_row("$GNDHV,,,0.000,1,*", 1'b1, field_of(KIND_DHV, 4'd4, 48'sd1, 3'd0, 1'b0, 1'b0));
		add_row("$GNGGA,,,,,W,-0.0,,*", 1'b0, '0);
		// Illegal characters, lone minus, and sentences ended early.
		add_row("$GNVTG,1.2.3*$GNVTG,12-3*$GNVTG,-*", 1'b0, '0);
		add_row("$GNVTG,12\r$GNVTG,12~", 1'b0, '0);
		// A dollar abandons the open sentence; text before the first comma is ignored.
		add_row("$GNVTG,12$GNVTG,34*", 1'b1, field_of(KIND_VTG, 4'd1, 48'sd34, 3'd0, 1'b0, 1'b0));
		add_row("$GNGGAxyz,12*", 1'b1, field_of(KIND_GGA, 4'd1, 48'sd12, 3'd0, 1'b0, 1'b0));
		// Tag mismatches and the comma count holding at its top.
		add_row("$GPGGA,1*$GNGGX,1*$GN$GNDH,1*", 1'b0, '0);
		add_row("$GNGGA,,,,,,,,,,,,,,,,,,,5*", 1'b0, '0);

		send_gap_pct <= 29;
		recv_stall_pct <= 61;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sentences.
		foreach (row_text[i]) begin
			if (row_typed[i]) begin
				field_q.push_back(row_exp[i]);
				typed_row = 1'b1;
			end
			for (int c = 0; c < row_text[i].len(); c++)
				send_byte(row_text[i][c]);
			typed_row = 1'b0;
		end

		// Random sentences under three idle patterns.
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				send_gap_pct <= 61;
				recv_stall_pct <= 29;
			end else if (ph == 2) begin
				send_gap_pct <= 0;
				recv_stall_pct <= 0;
			end
			sent = 0;
			while (sent < PHASE_BYTES) begin
				add_sentence();
				while (line_q.size() != 0) begin
					send_byte(line_q.pop_front());
					sent++;
				end
			end
		end

		in_valid <= 1'b0;
		while (field_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (err_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: nmea_field_extractor.f
hw/rtl/nfe_pkg.sv
hw/rtl/nfe_sentence.sv
hw/rtl/nfe_field_acc.sv
hw/rtl/nfe_result.sv
hw/rtl/nmea_field_extractor.sv
test/nmea_field_extractor_tb.sv
